### src/alr_pkg.sv
// Shared types and constants of the authentication line rewriter.
package alr_pkg;

	// Width of every length and index that the output sequencer walks through.
	localparam int LEN_W = 5;

	// Number of output sources, one mask bit each.
	localparam int NUM_PH = 6;

	// Length of the replacement line for the fd-passing negotiation request.
	localparam logic [LEN_W-1:0] NOP_LEN = 5'd13;

	// Output sources in the order in which they appear within one run.
	typedef enum logic [2:0] {
		PH_HELD = 3'd0,
		PH_NOP  = 3'd1,
		PH_UID  = 3'd2,
		PH_CR   = 3'd3,
		PH_BYTE = 3'd4,
		PH_LF   = 3'd5
	} phase_t;

	// What one input byte will emit: sources present and their lengths.
	typedef struct packed {
		logic [NUM_PH-1:0] mask;
		logic [LEN_W-1:0]  held_len;
		logic [LEN_W-1:0]  uid_len;
	} plan_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             emit;
		logic             last;
		phase_t           phase;
		logic [LEN_W-1:0] idx;
	} cmd_t;

endpackage

### src/alr_ctrl.sv
// Controller of the authentication line rewriter: input handshake and output sequencing.
module alr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  alr_pkg::plan_t plan,
	output alr_pkg::cmd_t  cmd
);
	import alr_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [NUM_PH-1:0] mask_q;
	logic [LEN_W-1:0]  held_len_q;
	logic [LEN_W-1:0]  uid_len_q;
	logic [LEN_W-1:0]  idx_q;
	logic              out_valid_q;

	phase_t            cur_ph;
	logic [LEN_W-1:0]  phase_len;
	logic              phase_done;
	logic [NUM_PH-1:0] rest_mask;
	logic              can_emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign can_emit  = !out_valid_q || out_ready;

	always_comb begin
		priority if (mask_q[PH_HELD]) cur_ph = PH_HELD;
		else if (mask_q[PH_NOP])      cur_ph = PH_NOP;
		else if (mask_q[PH_UID])      cur_ph = PH_UID;
		else if (mask_q[PH_CR])       cur_ph = PH_CR;
		else if (mask_q[PH_BYTE])     cur_ph = PH_BYTE;
		else                          cur_ph = PH_LF;

		unique case (cur_ph)
			PH_HELD: phase_len = held_len_q;
			PH_NOP:  phase_len = NOP_LEN;
			PH_UID:  phase_len = uid_len_q;
			default: phase_len = LEN_W'(1);
		endcase

		phase_done = ((idx_q + LEN_W'(1)) == phase_len);
		rest_mask  = mask_q & ~(NUM_PH'(1) << cur_ph);

		cmd.load  = in_valid && in_ready;
		cmd.emit  = (state_q == ST_RUN) && (mask_q != '0) && can_emit;
		cmd.last  = phase_done && (rest_mask == '0);
		cmd.phase = cur_ph;
		cmd.idx   = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			held_len_q  <= '0;
			uid_len_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						mask_q     <= plan.mask;
						held_len_q <= plan.held_len;
						uid_len_q  <= plan.uid_len;
						idx_q      <= '0;
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					// A byte that causes no output returns straight to idle.
					if (mask_q == '0) begin
						state_q <= ST_IDLE;
					end else if (cmd.emit) begin
						if (phase_done) begin
							mask_q <= rest_mask;
							idx_q  <= '0;
							if (rest_mask == '0) begin
								state_q <= ST_IDLE;
							end
						end else begin
							idx_q <= idx_q + LEN_W'(1);
						end
					end
				end
			endcase
		end
	end

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN)
		else $error("accepted transaction did not start an output run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE && mask_q == '0))
		else $error("final byte of a run did not return the controller to idle");

	a_held_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && mask_q[PH_HELD]) |-> held_len_q != '0)
		else $error("held bytes scheduled with zero length");

endmodule

### src/alr_datapath.sv
// Datapath of the authentication line rewriter: line state, held bytes and output byte.
module alr_datapath #(
	parameter int HOLD_DEPTH    = 17,
	parameter int MAX_ID_DIGITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic [7:0]     in_byte,
	input  alr_pkg::cmd_t  cmd,
	output alr_pkg::plan_t plan,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);
	import alr_pkg::*;

	localparam int HIDX_W = $clog2(HOLD_DEPTH);

	localparam logic CFG_DIGITS = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_HEX_HI = 8'h33;

	localparam logic [LEN_W-1:0] BEGIN_LEN = 5'd5;
	localparam logic [LEN_W-1:0] NUF_LEN   = 5'd17;
	localparam logic [LEN_W-1:0] AUTH_LEN  = 5'd14;

	localparam logic [8*5-1:0]  KW_BEGIN = "BEGIN";
	localparam logic [8*17-1:0] KW_NUF   = "NEGOTIATE_UNIX_FD";
	localparam logic [8*14-1:0] KW_AUTH  = "AUTH EXTERNAL ";
	localparam logic [8*13-1:0] KW_NOP   = "NEGOTIATE_NOP";
	localparam logic [8*16-1:0] HEX_LC   = "0123456789abcdef";

	typedef enum logic [1:0] {
		MODE_MATCH   = 2'd0,
		MODE_PASS    = 2'd1,
		MODE_DISCARD = 2'd2
	} mode_t;

	function automatic logic [7:0] begin_char(input logic [LEN_W-1:0] i);
		logic [7:0] c;
		c = CH_NUL;
		if (i < BEGIN_LEN) c = KW_BEGIN[8*(4-int'(i)) +: 8];
		return c;
	endfunction

	function automatic logic [7:0] nuf_char(input logic [LEN_W-1:0] i);
		logic [7:0] c;
		c = CH_NUL;
		if (i < NUF_LEN) c = KW_NUF[8*(16-int'(i)) +: 8];
		return c;
	endfunction

	function automatic logic [7:0] auth_char(input logic [LEN_W-1:0] i);
		logic [7:0] c;
		c = CH_NUL;
		if (i < AUTH_LEN) c = KW_AUTH[8*(13-int'(i)) +: 8];
		return c;
	endfunction

	function automatic logic [7:0] nop_char(input logic [LEN_W-1:0] i);
		logic [7:0] c;
		c = CH_NUL;
		if (i < NOP_LEN) c = KW_NOP[8*(12-int'(i)) +: 8];
		return c;
	endfunction

	// Configuration.
	logic [31:0] uid_digits_q;
	logic [3:0]  uid_count_q;

	// Line state.
	logic             auth_q;
	logic             first_q;
	logic [LEN_W-1:0] hc_q;
	logic [2:0]       cand_q;
	mode_t            mode_q;
	logic             pend_q;
	logic [7:0]       held_q [HOLD_DEPTH];
	logic [7:0]       byte_q;
	logic [7:0]       out_byte_q;
	logic             last_q;

	logic             auth_n;
	logic             first_n;
	logic [LEN_W-1:0] hc_n;
	logic [2:0]       cand_n;
	mode_t            mode_n;
	logic             pend_n;
	logic             store;
	logic             end_ln;
	logic [2:0]       hit;
	logic             is_cr;
	logic             is_lf;
	logic             held_any;
	logic             hc_full;
	logic [3:0]       uid_n;
	logic [2:0]       nib_sel;
	logic [3:0]       digit;
	logic [7:0]       emit_byte;

	// Digit count is clamped into the supported range.
	always_comb begin
		uid_n = uid_count_q;
		if (uid_n == 4'd0) uid_n = 4'd1;
		if (uid_n > 4'(MAX_ID_DIGITS)) uid_n = 4'(MAX_ID_DIGITS);
	end

	assign is_cr    = (in_byte == CH_CR);
	assign is_lf    = (in_byte == CH_LF);
	assign held_any = (hc_q != '0);
	assign hc_full  = ({1'b0, hc_q} >= 6'(HOLD_DEPTH));

	assign hit[0] = cand_q[0] && (hc_q < BEGIN_LEN) && (begin_char(hc_q) == in_byte);
	assign hit[1] = cand_q[1] && (hc_q < NUF_LEN) && (nuf_char(hc_q) == in_byte);
	assign hit[2] = cand_q[2] && (hc_q < AUTH_LEN) && (auth_char(hc_q) == in_byte);

	always_comb begin
		plan          = '0;
		plan.held_len = hc_q;
		plan.uid_len  = {uid_n, 1'b0};
		auth_n  = auth_q;
		first_n = first_q;
		hc_n    = hc_q;
		cand_n  = cand_q;
		mode_n  = mode_q;
		pend_n  = pend_q;
		store   = 1'b0;
		end_ln  = 1'b0;

		priority if (auth_q) begin
			plan.mask[PH_BYTE] = 1'b1;
		end else if (!first_q && in_byte == CH_NUL) begin
			first_n            = 1'b1;
			plan.mask[PH_BYTE] = 1'b1;
		end else begin
			first_n = 1'b1;
			unique case (mode_q)
				MODE_MATCH: begin
					if (pend_q) begin
						if (is_lf) begin
							// The line ends here: decide which keyword it was.
							if (cand_q[0] && hc_q == BEGIN_LEN) begin
								plan.mask[PH_HELD] = 1'b1;
								auth_n             = 1'b1;
							end else if (cand_q[1] && hc_q == NUF_LEN) begin
								plan.mask[PH_NOP] = 1'b1;
							end else begin
								plan.mask[PH_HELD] = held_any;
							end
							plan.mask[PH_CR] = 1'b1;
							plan.mask[PH_LF] = 1'b1;
							end_ln           = 1'b1;
						end else begin
							// A lone CR breaks the match; the line passes from here on.
							plan.mask[PH_HELD] = held_any;
							plan.mask[PH_CR]   = 1'b1;
							plan.mask[PH_BYTE] = !is_cr;
							pend_n             = is_cr;
							hc_n               = '0;
							mode_n             = MODE_PASS;
						end
					end else if (is_cr) begin
						pend_n = 1'b1;
					end else if (hit == 3'b000 || hc_full) begin
						plan.mask[PH_HELD] = held_any;
						plan.mask[PH_BYTE] = 1'b1;
						hc_n               = '0;
						mode_n             = MODE_PASS;
					end else begin
						store  = 1'b1;
						hc_n   = hc_q + LEN_W'(1);
						cand_n = hit;
						if (hit[2] && hc_q == (AUTH_LEN - LEN_W'(1))) begin
							plan.mask[PH_HELD] = 1'b1;
							plan.mask[PH_UID]  = 1'b1;
							plan.held_len      = AUTH_LEN;
							hc_n               = '0;
							mode_n             = MODE_DISCARD;
						end
					end
				end
				MODE_PASS: begin
					if (is_cr) begin
						plan.mask[PH_CR] = pend_q;
						pend_n           = 1'b1;
					end else if (is_lf && pend_q) begin
						plan.mask[PH_CR] = 1'b1;
						plan.mask[PH_LF] = 1'b1;
						end_ln           = 1'b1;
					end else begin
						plan.mask[PH_CR]   = pend_q;
						plan.mask[PH_BYTE] = 1'b1;
						pend_n             = 1'b0;
					end
				end
				default: begin
					if (is_cr) begin
						pend_n = 1'b1;
					end else if (is_lf && pend_q) begin
						plan.mask[PH_CR] = 1'b1;
						plan.mask[PH_LF] = 1'b1;
						end_ln           = 1'b1;
					end else begin
						pend_n = 1'b0;
					end
				end
			endcase
		end

		if (end_ln) begin
			hc_n   = '0;
			cand_n = 3'b111;
			mode_n = MODE_MATCH;
			pend_n = 1'b0;
		end
	end

	// User id characters: an even index gives the high hex digit of the ASCII code.
	assign nib_sel = 3'(uid_n - 4'd1 - {1'b0, cmd.idx[LEN_W-1:1]});
	assign digit   = uid_digits_q[4*nib_sel +: 4];

	// Held bytes are read from the memory in the clocked block below.
	always_comb begin
		unique case (cmd.phase)
			PH_HELD: emit_byte = CH_NUL;
			PH_NOP:  emit_byte = nop_char(cmd.idx);
			PH_UID:  emit_byte = cmd.idx[0] ? HEX_LC[8*(15-int'(digit)) +: 8] : CH_HEX_HI;
			PH_CR:   emit_byte = CH_CR;
			PH_BYTE: emit_byte = byte_q;
			PH_LF:   emit_byte = CH_LF;
			default: emit_byte = CH_NUL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_digits_q <= '0;
			uid_count_q  <= 4'd1;
			auth_q       <= 1'b0;
			first_q      <= 1'b0;
			hc_q         <= '0;
			cand_q       <= 3'b111;
			mode_q       <= MODE_MATCH;
			pend_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DIGITS: uid_digits_q <= cfg_data;
					CFG_COUNT:  uid_count_q  <= cfg_data[3:0];
				endcase
			end
			if (cmd.load) begin
				auth_q  <= auth_n;
				first_q <= first_n;
				hc_q    <= hc_n;
				cand_q  <= cand_n;
				mode_q  <= mode_n;
				pend_q  <= pend_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte;
			if (store) held_q[hc_q[HIDX_W-1:0]] <= in_byte;
		end
		if (cmd.emit) begin
			if (cmd.phase == PH_HELD) begin
				out_byte_q <= held_q[cmd.idx[HIDX_W-1:0]];
			end else begin
				out_byte_q <= emit_byte;
			end
			last_q <= cmd.last;
		end
	end

	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q <= NUF_LEN)
		else $error("held byte count beyond the longest keyword");

	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DISCARD) |-> hc_q == '0)
		else $error("bytes held while discarding a line tail");

	a_auth_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(auth_q) |-> (mode_q == MODE_MATCH && hc_q == '0 && !pend_q))
		else $error("pass-through entered without a clean line state");

endmodule

### src/auth_line_rewriter.sv
// Top level of the authentication line rewriter.
// Rewrites a CR LF text authentication stream one byte per input transaction:
// a line that asks for Unix fd passing becomes a no-op negotiation line, the
// tail of an AUTH EXTERNAL line is replaced by the configured user id in
// hex-coded ASCII, and a BEGIN line switches the block to plain pass-through.
// An input byte is taken first, then its output bytes follow one by one,
// since the sequencer loads the single output register once per cycle while
// the output is not stalled (a run is at most 30 bytes). A byte that causes
// no output still passes through the run state. A new byte is taken as soon
// as the previous run has been loaded, even while its last byte still waits
// on the output. Configuration writes take effect at once and should be made
// only while no run is in progress; no clearing pass follows reset.
module auth_line_rewriter #(
	parameter int HOLD_DEPTH    = 17,
	parameter int MAX_ID_DIGITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);
	import alr_pkg::*;

	plan_t plan;
	cmd_t  cmd;

	alr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.plan      (plan),
		.cmd       (cmd)
	);

	alr_datapath #(
		.HOLD_DEPTH    (HOLD_DEPTH),
		.MAX_ID_DIGITS (MAX_ID_DIGITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_byte     (in_byte),
		.cmd         (cmd),
		.plan        (plan),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
